// ===== rtl/rcwc_pkg.sv =====
`default_nettype none
package rcwc_pkg;

	localparam int SEQ_W   = 32;
	localparam int WIN_W   = 32;
	localparam int MSS_W   = 16;
	localparam int PWIN_W  = 16;
	localparam int LEN_W   = 16;
	localparam int RETRY_W = 4;
	localparam int CFG_W   = 21;
	localparam int DIV_W   = 32;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [MSS_W-1:0]   MSS_RESET     = 16'd1024;
	localparam logic [WIN_W-1:0]   WINDOW_RESET  = 32'd1024;
	localparam logic [WIN_W-1:0]   THRESH_RESET  = 32'd65536;
	localparam logic [RETRY_W-1:0] RETRIES_RESET = 4'd8;
	localparam logic [RETRY_W-1:0] COUNT_MAX     = 4'd15;
	localparam logic [RETRY_W-1:0] DUP_TRIGGER   = 4'd3;

	typedef enum logic [0:0] {
		OP_ACK   = 1'b0,
		OP_TIMER = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_SLOW  = 2'd0,
		PH_AVOID = 2'd1,
		PH_FAST  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RS_NONE    = 2'd0,
		RS_FAST    = 2'd1,
		RS_TIMEOUT = 2'd2
	} resend_t;

	typedef enum logic [1:0] {
		CFG_MSS            = 2'd0,
		CFG_INIT_WINDOW    = 2'd1,
		CFG_INIT_THRESHOLD = 2'd2,
		CFG_MAX_RETRIES    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DECIDE,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_CREDIT,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic             we;
		cfg_idx_t         index;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	// An event after classification, as it sits in the queue.
	typedef struct packed {
		op_t                op;
		logic [SEQ_W-1:0]   ack_num;
		logic [PWIN_W-1:0]  peer_window;
		logic [SEQ_W-1:0]   seg_seq;
		logic [LEN_W-1:0]   seg_len;
		logic [RETRY_W-1:0] retry_count;
		logic [SEQ_W-1:0]   next_seq;
		logic [SEQ_W-1:0]   data_end;
		logic [SEQ_W:0]     seg_end;
		logic               seg_tail;
		logic [LEN_W:0]     data_room;
	} evt_entry_t;

	typedef struct packed {
		logic       valid;
		evt_entry_t entry;
	} q_stat_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rcwc_if.sv =====
`default_nettype none
interface rcwc_in_if import rcwc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [SEQ_W-1:0]   ack_num;
	logic [PWIN_W-1:0]  peer_window;
	logic [SEQ_W-1:0]   seg_seq;
	logic [LEN_W-1:0]   seg_len;
	logic [RETRY_W-1:0] retry_count;
	logic [SEQ_W-1:0]   next_seq;
	logic [SEQ_W-1:0]   data_end;

	modport source (
		output valid, operation, ack_num, peer_window, seg_seq, seg_len,
		       retry_count, next_seq, data_end,
		input  ready
	);
	modport sink (
		input  valid, operation, ack_num, peer_window, seg_seq, seg_len,
		       retry_count, next_seq, data_end,
		output ready
	);
endinterface

interface rcwc_out_if import rcwc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WIN_W-1:0]   cwnd_out;
	logic [WIN_W-1:0]   threshold_out;
	logic [1:0]         phase_out;
	logic [MSS_W-1:0]   send_credit;
	logic [1:0]         resend;
	logic [SEQ_W-1:0]   resend_seq;
	logic [LEN_W-1:0]   resend_len;
	logic [RETRY_W-1:0] rearm_count;
	logic               fatal;

	modport source (
		output valid, cwnd_out, threshold_out, phase_out, send_credit, resend,
		       resend_seq, resend_len, rearm_count, fatal,
		input  ready
	);
	modport sink (
		input  valid, cwnd_out, threshold_out, phase_out, send_credit, resend,
		       resend_seq, resend_len, rearm_count, fatal,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/rcwc_front.sv =====
`default_nettype none
module rcwc_front import rcwc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rcwc_in_if.sink    evt,
	output q_stat_t    qs,
	input  wire logic  q_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	evt_entry_t     mem_q [DEPTH];
	evt_entry_t     entry;
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic [SEQ_W:0] room_diff;

	// Classification needs only the item itself, so it is done on the way in.
	always_comb begin
		entry             = '0;
		entry.op          = op_t'(evt.operation);
		entry.ack_num     = evt.ack_num;
		entry.peer_window = evt.peer_window;
		entry.seg_seq     = evt.seg_seq;
		entry.seg_len     = evt.seg_len;
		entry.retry_count = evt.retry_count;
		entry.next_seq    = evt.next_seq;
		entry.data_end    = evt.data_end;
		entry.seg_end     = {1'b0, evt.seg_seq} + {{(SEQ_W - LEN_W + 1){1'b0}}, evt.seg_len};
		entry.seg_tail    = (evt.seg_seq == evt.next_seq) && (evt.seg_len == '0);
		room_diff         = {1'b0, evt.data_end} - {1'b0, evt.next_seq};
		// Room left in user data, saturated just above any segment size.
		if (room_diff[SEQ_W]) begin
			entry.data_room = '0;
		end else if (room_diff[SEQ_W-1:LEN_W] != '0) begin
			entry.data_room = {1'b1, {LEN_W{1'b0}}};
		end else begin
			entry.data_room = {1'b0, room_diff[LEN_W-1:0]};
		end
	end

	assign evt.ready = (count_q != CW'(DEPTH));
	assign push      = evt.valid && evt.ready;
	assign qs.valid  = (count_q != '0);
	assign qs.entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rcwc_div.sv =====
`default_nettype none
module rcwc_div import rcwc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int NW = $clog2(DIV_W + 1);

	logic [NW-1:0]    cnt_q;
	logic             done_q;
	logic [DIV_W-1:0] quo_q, rem_q, dsr_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W+1:0] trial;

	// Restoring division, one quotient bit per cycle, dividend shifted out
	// of the quotient register as the quotient bits shift in.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == NW'(1));
			if (req.start) begin
				cnt_q <= NW'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (trial[DIV_W+1]) begin
				rem_q <= shifted[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], ~trial[DIV_W+1]};
		end
	end

	assign rsp.busy     = (cnt_q != '0);
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/rcwc_back.sv =====
`default_nettype none
module rcwc_back import rcwc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_wr_t  cfg,
	input  wire q_stat_t  qs,
	output logic          q_pop,
	output div_req_t      div_req,
	input  wire div_rsp_t div_rsp,
	rcwc_out_if.source    res
);

	function automatic logic [WIN_W-1:0] sat32(input logic [WIN_W:0] s);
		sat32 = s[WIN_W] ? '1 : s[WIN_W-1:0];
	endfunction

	// Difference clamped at zero and then at the segment size.
	function automatic logic [MSS_W-1:0] clamp_mss(input logic [SEQ_W+1:0] v,
	                                              input logic [MSS_W-1:0] m);
		if (v[SEQ_W+1]) begin
			clamp_mss = '0;
		end else if (v > {{(SEQ_W - MSS_W + 2){1'b0}}, m}) begin
			clamp_mss = m;
		end else begin
			clamp_mss = v[MSS_W-1:0];
		end
	endfunction

	bk_state_t state_q, state_d;
	evt_entry_t item_q;

	logic [SEQ_W-1:0]   base_q, lra_q;
	logic [WIN_W-1:0]   cong_q, thr_q;
	logic [RETRY_W-1:0] dup_q, maxr_q;
	phase_t             phase_q;
	logic [PWIN_W-1:0]  recv_q;
	logic [MSS_W-1:0]   mss_q;

	resend_t            rs_q;
	logic [SEQ_W-1:0]   rseq_q;
	logic [LEN_W-1:0]   rlen_q;
	logic [RETRY_W-1:0] rearm_q;
	logic               fatal_q;
	logic [DIV_W-1:0]   sq_q;
	logic [MSS_W-1:0]   c1_q, c3_q;

	logic               out_valid_q;
	logic [WIN_W-1:0]   cwnd_out_q, thr_out_q;
	phase_t             phase_out_q;
	logic [MSS_W-1:0]   credit_out_q;
	resend_t            rs_out_q;
	logic [SEQ_W-1:0]   rseq_out_q;
	logic [LEN_W-1:0]   rlen_out_q;
	logic [RETRY_W-1:0] rearm_out_q;
	logic               fatal_out_q;

	logic [SEQ_W-1:0]   base_d, lra_d;
	logic [WIN_W-1:0]   cong_d, thr_d;
	logic [RETRY_W-1:0] dup_d;
	phase_t             phase_d;
	logic [PWIN_W-1:0]  recv_d;
	resend_t            rs_d;
	logic [SEQ_W-1:0]   rseq_d;
	logic [LEN_W-1:0]   rlen_d;
	logic [RETRY_W-1:0] rearm_d;
	logic               fatal_d;
	logic               grow_avoid;

	logic [WIN_W-1:0]   cong_half, cong_plus_mss, fast_cong;
	logic [RETRY_W-1:0] dup_inc, rearm_inc;
	logic [MSS_W+1:0]   mss3;
	logic [SEQ_W:0]     lra_room;
	logic [LEN_W-1:0]   fast_len;
	logic               pending;
	logic [SEQ_W+1:0]   w_recv, w_cong;
	logic [MSS_W-1:0]   credit_min, credit;
	logic               out_free, out_load;

	// Decision of one event from the current state.
	always_comb begin
		cong_half     = {1'b0, cong_q[WIN_W-1:1]};
		cong_plus_mss = sat32({1'b0, cong_q} + {{(WIN_W - MSS_W + 1){1'b0}}, mss_q});
		mss3          = {2'b00, mss_q} + {1'b0, mss_q, 1'b0};
		fast_cong     = sat32({1'b0, cong_half} + {{(WIN_W - MSS_W - 1){1'b0}}, mss3});
		dup_inc       = (dup_q == COUNT_MAX) ? dup_q : dup_q + RETRY_W'(1);
		rearm_inc     = (item_q.retry_count == COUNT_MAX) ? COUNT_MAX
		                : item_q.retry_count + RETRY_W'(1);
		lra_room      = {1'b0, item_q.data_end} - {1'b0, lra_q};
		if (lra_room[SEQ_W]) begin
			fast_len = '0;
		end else if (lra_room[SEQ_W-1:0] > {{(SEQ_W - MSS_W){1'b0}}, mss_q}) begin
			fast_len = mss_q;
		end else begin
			fast_len = lra_room[LEN_W-1:0];
		end
		pending = (item_q.seg_end > {1'b0, base_q}) || item_q.seg_tail;

		base_d     = base_q;
		lra_d      = lra_q;
		cong_d     = cong_q;
		thr_d      = thr_q;
		dup_d      = dup_q;
		phase_d    = phase_q;
		recv_d     = recv_q;
		rs_d       = RS_NONE;
		rseq_d     = '0;
		rlen_d     = '0;
		rearm_d    = '0;
		fatal_d    = 1'b0;
		grow_avoid = 1'b0;

		if (item_q.op == OP_ACK) begin
			recv_d = item_q.peer_window;
			if (item_q.ack_num > base_q) begin
				base_d = item_q.ack_num;
				unique case (phase_q)
					PH_SLOW: begin
						cong_d = cong_plus_mss;
						if (cong_plus_mss > thr_q) begin
							phase_d = PH_AVOID;
						end
					end
					PH_AVOID: begin
						grow_avoid = 1'b1;
					end
					PH_FAST: begin
						cong_d  = thr_q;
						dup_d   = '0;
						phase_d = PH_AVOID;
					end
					default: begin
					end
				endcase
			end else if (item_q.ack_num == lra_q) begin
				dup_d = dup_inc;
				if (phase_q == PH_FAST) begin
					cong_d = cong_plus_mss;
				end else if (dup_inc >= DUP_TRIGGER) begin
					thr_d   = cong_half;
					cong_d  = fast_cong;
					phase_d = PH_FAST;
					rs_d    = RS_FAST;
					rseq_d  = lra_q;
					rlen_d  = fast_len;
				end
			end else begin
				dup_d = '0;
				lra_d = item_q.ack_num;
			end
		end else if (pending) begin
			if (item_q.retry_count > maxr_q) begin
				fatal_d = 1'b1;
			end else begin
				rs_d    = RS_TIMEOUT;
				rseq_d  = item_q.seg_seq;
				rlen_d  = item_q.seg_len;
				rearm_d = rearm_inc;
				thr_d   = cong_half;
				cong_d  = {{(WIN_W - MSS_W){1'b0}}, mss_q};
				dup_d   = '0;
				phase_d = PH_SLOW;
			end
		end
	end

	assign w_recv = {2'b00, base_q} + {{(SEQ_W - PWIN_W + 2){1'b0}}, recv_q}
	                - {2'b00, item_q.next_seq};
	assign w_cong = {2'b00, base_q} + {2'b00, cong_q} - {2'b00, item_q.next_seq};

	assign credit_min = (c1_q < c3_q) ? c1_q : c3_q;
	assign credit     = ({1'b0, credit_min} < item_q.data_room) ? credit_min
	                    : item_q.data_room[MSS_W-1:0];

	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		state_d               = state_q;
		q_pop                 = 1'b0;
		out_load              = 1'b0;
		div_req.start         = 1'b0;
		div_req.dividend      = sq_q;
		div_req.divisor       = (cong_q == '0) ? DIV_W'(1) : cong_q;
		unique case (state_q)
			BK_IDLE: begin
				if (qs.valid) begin
					q_pop   = 1'b1;
					state_d = BK_DECIDE;
				end
			end
			BK_DECIDE: begin
				state_d = grow_avoid ? BK_DIV_GO : BK_CREDIT;
			end
			BK_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = BK_DIV_WAIT;
			end
			BK_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = BK_CREDIT;
				end
			end
			BK_CREDIT: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Connection state and configuration. The user must write configuration only while
	// no event is in flight, so it never meets a datapath update; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			lra_q   <= '0;
			dup_q   <= '0;
			cong_q  <= WINDOW_RESET;
			thr_q   <= THRESH_RESET;
			phase_q <= PH_SLOW;
			recv_q  <= '0;
			mss_q   <= MSS_RESET;
			maxr_q  <= RETRIES_RESET;
		end else begin
			if (state_q == BK_DECIDE) begin
				base_q  <= base_d;
				lra_q   <= lra_d;
				dup_q   <= dup_d;
				cong_q  <= cong_d;
				thr_q   <= thr_d;
				phase_q <= phase_d;
				recv_q  <= recv_d;
			end else if (state_q == BK_DIV_WAIT && div_rsp.done) begin
				cong_q <= sat32({1'b0, cong_q} + {1'b0, div_rsp.quotient});
			end
			if (cfg.we) begin
				unique case (cfg.index)
					CFG_MSS:            mss_q  <= cfg.data[MSS_W-1:0];
					CFG_INIT_WINDOW:    cong_q <= {{(WIN_W - CFG_W){1'b0}}, cfg.data};
					CFG_INIT_THRESHOLD: thr_q  <= {{(WIN_W - CFG_W){1'b0}}, cfg.data};
					CFG_MAX_RETRIES:    maxr_q <= cfg.data[RETRY_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= qs.entry;
		end
		if (state_q == BK_DECIDE) begin
			rs_q    <= rs_d;
			rseq_q  <= rseq_d;
			rlen_q  <= rlen_d;
			rearm_q <= rearm_d;
			fatal_q <= fatal_d;
			sq_q    <= {{(DIV_W - MSS_W){1'b0}}, mss_q} * {{(DIV_W - MSS_W){1'b0}}, mss_q};
		end
		if (state_q == BK_CREDIT) begin
			c1_q <= clamp_mss(w_recv, mss_q);
			c3_q <= clamp_mss(w_cong, mss_q);
		end
		if (out_load) begin
			cwnd_out_q   <= cong_q;
			thr_out_q    <= thr_q;
			phase_out_q  <= phase_q;
			credit_out_q <= credit;
			rs_out_q     <= rs_q;
			rseq_out_q   <= rseq_q;
			rlen_out_q   <= rlen_q;
			rearm_out_q  <= rearm_q;
			fatal_out_q  <= fatal_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.cwnd_out      = cwnd_out_q;
	assign res.threshold_out = thr_out_q;
	assign res.phase_out     = phase_out_q;
	assign res.send_credit   = credit_out_q;
	assign res.resend        = rs_out_q;
	assign res.resend_seq    = rseq_out_q;
	assign res.resend_len    = rlen_out_q;
	assign res.rearm_count   = rearm_out_q;
	assign res.fatal         = fatal_out_q;

endmodule
`default_nettype wire

// ===== rtl/reno_congestion_window_control_top.sv =====
`default_nettype none
// Channel   Direction  Carries
// evt       in         one ack or timer event per item
// res       out        one window/credit/retransmit result per item
// cfg       in         register writes: mss, initial window, threshold, retries
//
// An event is written into a queue of QDEPTH items on the cycle it is accepted.
// The back end takes one event at a time through its decide, credit and output
// states, holding in the last until the result register is free; an ack that grows
// the window in congestion avoidance also runs the 32-step restoring divider computing mss*mss/cwnd.
// Reset clears the queue, the connection state and the result valid flag at once;
// there is no clearing pass. A stalled result holds the back end, while the
// front keeps taking events until the queue is full.
module reno_congestion_window_control_top import rcwc_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	rcwc_in_if.sink               evt,
	rcwc_out_if.source            res,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	cfg_wr_t  cfg;
	q_stat_t  qs;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_idx_t'(cfg_index);
	assign cfg.data  = cfg_data;

	// The front classifies each event and buffers it, so that incoming events
	// are not held up while the back end waits on the divider or on the sink, until the queue is full.
	rcwc_front #(
		.DEPTH (QDEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.qs     (qs),
		.q_pop  (q_pop)
	);

	// The divider serves only the window growth of congestion avoidance.
	rcwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The back end owns the connection state and the result register.
	rcwc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.qs      (qs),
		.q_pop   (q_pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.res     (res)
	);

	// The back end never takes an event from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> qs.valid)
		else $error("queue popped while empty");

	// The divider is never restarted while a division is running.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A fatal result never orders a retransmit.
	a_fatal_no_resend: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.fatal) |-> (res.resend == RS_NONE))
		else $error("fatal result with a retransmit order");

	// Without a retransmit order the segment fields are all zero.
	a_no_resend_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.resend == RS_NONE) |->
			(res.resend_seq == '0 && res.resend_len == '0 && res.rearm_count == '0))
		else $error("segment fields set without a retransmit order");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb import rcwc_pkg::*; ();

	// One event as the sender presents it on the evt channel.
	typedef struct packed {
		op_t                operation;
		logic [SEQ_W-1:0]   ack_num;
		logic [PWIN_W-1:0]  peer_window;
		logic [SEQ_W-1:0]   seg_seq;
		logic [LEN_W-1:0]   seg_len;
		logic [RETRY_W-1:0] retry_count;
		logic [SEQ_W-1:0]   next_seq;
		logic [SEQ_W-1:0]   data_end;
	} reno_evt_t;

	// One window result as it leaves on the res channel.
	typedef struct packed {
		logic [WIN_W-1:0]   cwnd;
		logic [WIN_W-1:0]   thresh;
		phase_t             ph;
		logic [MSS_W-1:0]   credit;
		resend_t            rs;
		logic [SEQ_W-1:0]   rseq;
		logic [LEN_W-1:0]   rlen;
		logic [RETRY_W-1:0] rearm;
		logic               fatal;
	} win_res_t;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rcwc_in_if  evt ();
	rcwc_out_if res ();

	reno_congestion_window_control_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The connection as the sender sees it: our own copy of the Reno state
	// and of the registers that steer it.
	logic [SEQ_W-1:0]   snd_una;
	logic [SEQ_W-1:0]   dup_ack_seq;
	logic [RETRY_W-1:0] dup_acks;
	logic [WIN_W-1:0]   cwnd;
	logic [WIN_W-1:0]   ssthresh;
	phase_t             cc_phase;
	logic [PWIN_W-1:0]  rwnd;
	logic [MSS_W-1:0]   seg_size;
	logic [RETRY_W-1:0] retry_limit;

	reno_evt_t   pending_events[$];
	win_res_t    due_results[$];
	reno_evt_t   on_wire;
	int          faults;
	int unsigned cycles;
	int          send_gap_pct;
	int          take_gap_pct;

	// Highest send base the stimulus has pushed so far. The generator runs
	// ahead of the prediction, so it keeps this on its own.
	logic [SEQ_W-1:0] flow_base;

	function automatic logic [WIN_W-1:0] sat_sum(input logic [63:0] a,
		input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'hFFFF_FFFF) ? '1 : s[WIN_W-1:0];
	endfunction

	function automatic logic [63:0] gap(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic logic [63:0] least(input logic [63:0] a, input logic [63:0] b);
		return (a < b) ? a : b;
	endfunction

	// Puts one event at the tail of the sender's list.
	function automatic void add_event(input reno_evt_t e);
		pending_events.insert(pending_events.size(), e);
	endfunction

	// Applies one event to the connection state and returns the result
	// the block has to produce for it.
	function automatic win_res_t reno_react(input reno_evt_t e);
		win_res_t    r;
		logic [63:0] q;
		logic [63:0] dvs;
		logic        due;
		r = '0;
		if (e.operation == OP_ACK) begin
			rwnd = e.peer_window;
			if (e.ack_num > snd_una) begin
				snd_una = e.ack_num;
				case (cc_phase)
				PH_SLOW: begin
					cwnd = sat_sum(cwnd, seg_size);
					if (cwnd > ssthresh)
						cc_phase = PH_AVOID;
				end
				PH_AVOID: begin
					q = {48'd0, seg_size} * {48'd0, seg_size};
					dvs = (cwnd != 0) ? {32'd0, cwnd} : 64'd1;
					cwnd = sat_sum(cwnd, q / dvs);
				end
				default: begin
					cwnd = ssthresh;
					dup_acks = '0;
					cc_phase = PH_AVOID;
				end
				endcase
			end else if (e.ack_num == dup_ack_seq) begin
				if (dup_acks != COUNT_MAX)
					dup_acks = dup_acks + 1'b1;
				if (cc_phase == PH_FAST) begin
					cwnd = sat_sum(cwnd, seg_size);
				end else if (dup_acks >= DUP_TRIGGER) begin
					ssthresh = cwnd >> 1;
					cwnd = sat_sum(ssthresh, 64'd3 * seg_size);
					cc_phase = PH_FAST;
					r.rs = RS_FAST;
					r.rseq = dup_ack_seq;
					r.rlen = LEN_W'(least(seg_size, gap(e.data_end, dup_ack_seq)));
				end
			end else begin
				dup_acks = '0;
				dup_ack_seq = e.ack_num;
			end
		end else begin
			due = ({32'd0, e.seg_seq} + e.seg_len > snd_una) ||
			      (e.seg_seq == e.next_seq && e.seg_len == 0);
			if (due) begin
				if (e.retry_count > retry_limit) begin
					r.fatal = 1'b1;
				end else begin
					r.rs = RS_TIMEOUT;
					r.rseq = e.seg_seq;
					r.rlen = e.seg_len;
					r.rearm = (e.retry_count == COUNT_MAX) ? COUNT_MAX
					                                       : e.retry_count + 1'b1;
					ssthresh = cwnd >> 1;
					cwnd = {16'd0, seg_size};
					dup_acks = '0;
					cc_phase = PH_SLOW;
				end
			end
		end
		q = seg_size;
		q = least(q, gap({32'd0, snd_una} + rwnd, e.next_seq));
		q = least(q, gap(e.data_end, e.next_seq));
		q = least(q, gap({32'd0, snd_una} + cwnd, e.next_seq));
		r.credit = q[MSS_W-1:0];
		r.cwnd = cwnd;
		r.thresh = ssthresh;
		r.ph = cc_phase;
		return r;
	endfunction

	function automatic string show(input win_res_t r);
		return $sformatf({"cwnd=%h thresh=%h phase=%0d credit=%0d resend=%0d",
			" seq=%h len=%0d rearm=%0d fatal=%b"},
			r.cwnd, r.thresh, r.ph, r.credit, r.rs, r.rseq, r.rlen, r.rearm, r.fatal);
	endfunction

	function automatic reno_evt_t ack_evt(input logic [SEQ_W-1:0] ack,
		input logic [PWIN_W-1:0] pwin, input logic [SEQ_W-1:0] nseq,
		input logic [SEQ_W-1:0] dend);
		reno_evt_t e;
		e = '0;
		e.operation = OP_ACK;
		e.ack_num = ack;
		e.peer_window = pwin;
		e.next_seq = nseq;
		e.data_end = dend;
		return e;
	endfunction

	function automatic reno_evt_t timer_evt(input logic [SEQ_W-1:0] sseq,
		input logic [LEN_W-1:0] slen, input logic [RETRY_W-1:0] retry,
		input logic [SEQ_W-1:0] nseq, input logic [SEQ_W-1:0] dend);
		reno_evt_t e;
		e = '0;
		e.operation = OP_TIMER;
		e.seg_seq = sseq;
		e.seg_len = slen;
		e.retry_count = retry;
		e.next_seq = nseq;
		e.data_end = dend;
		return e;
	endfunction

	// Places the sender's next unsent byte and the end of its data a little
	// past the send base; now and then the data ends below next_seq.
	function automatic reno_evt_t with_flow(input reno_evt_t e);
		e.next_seq = flow_base + $urandom_range(0, 3 * seg_size);
		if ($urandom_range(9) == 0)
			e.data_end = e.next_seq - $urandom_range(0, seg_size);
		else
			e.data_end = e.next_seq + $urandom_range(0, 2 * seg_size);
		return e;
	endfunction

	// A register write lands at the edge after the one where it is driven.
	// The connection is idle whenever this runs, so our copy follows at once.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		CFG_MSS:            seg_size = val[MSS_W-1:0];
		CFG_INIT_WINDOW:    cwnd = val;
		CFG_INIT_THRESHOLD: ssthresh = val;
		CFG_MAX_RETRIES:    retry_limit = val[RETRY_W-1:0];
		endcase
	endtask

	task automatic end_writes;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Holds the sender back until every item has gone through and every
	// result has come out.
	task automatic drain;
		@(negedge clk);
		while (pending_events.size() != 0 || evt.valid || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random traffic that mostly follows a live connection: new acks that
	// move the base, bursts of repeated acks that can reach fast retransmit,
	// timeouts of segments still in flight, stale timeouts, zero-length
	// probes at next_seq, and a share of plain noise.
	task automatic queue_traffic(input int count, input logic [1:0] era);
		reno_evt_t   e;
		int          made;
		int          pick;
		int          k;
		logic [31:0] r;
		r = $urandom;
		// Each era starts the base in its own quarter of the sequence space
		// so the upper bits of the sequence fields all get exercised.
		flow_base = {era, 2'b01, r[27:0]};
		add_event(with_flow(ack_evt(flow_base, r[15:0], 0, 0)));
		made = 1;
		while (made < count) begin
			pick = $urandom_range(99);
			r = $urandom;
			if (pick < 35) begin
				flow_base = flow_base + $urandom_range(1, 4) * seg_size
				            + $urandom_range(0, seg_size);
				add_event(with_flow(ack_evt(flow_base, r[15:0], 0, 0)));
				made++;
			end else if (pick < 60) begin
				// The first copy is recorded, the rest are counted.
				k = $urandom_range(2, 7);
				repeat (k) begin
					r = $urandom;
					add_event(with_flow(ack_evt(flow_base, r[15:0], 0, 0)));
				end
				made += k;
			end else if (pick < 80) begin
				e = timer_evt(flow_base - $urandom_range(0, 2 * seg_size), 0, 0, 0, 0);
				e.seg_len = flow_base - e.seg_seq + $urandom_range(1, seg_size);
				e.retry_count = ($urandom_range(3) == 0) ? $urandom_range(15)
				                                         : $urandom_range(2);
				add_event(with_flow(e));
				made++;
			end else if (pick < 87) begin
				e = timer_evt(flow_base - $urandom_range(70000, 200000), r[15:0],
					r[19:16], 0, 0);
				add_event(with_flow(e));
				made++;
			end else if (pick < 92) begin
				e = with_flow(timer_evt(0, 0, r[3:0], 0, 0));
				e.seg_seq = e.next_seq;
				add_event(e);
				made++;
			end else begin
				e.operation = r[0] ? OP_TIMER : OP_ACK;
				e.ack_num = $urandom_range(flow_base);
				e.peer_window = $urandom;
				e.seg_seq = $urandom;
				e.seg_len = $urandom;
				e.retry_count = $urandom;
				e.next_seq = $urandom;
				e.data_end = $urandom;
				add_event(e);
				made++;
			end
		end
	endtask

	// One random era: wait for the block to go idle, set the idle rates,
	// load the registers and queue the traffic.
	task automatic run_era(input logic [1:0] era, input int send_gap, input int take_gap,
		input logic [CFG_W-1:0] mss_val, input logic [CFG_W-1:0] win_val,
		input logic [CFG_W-1:0] thr_val, input logic [CFG_W-1:0] retry_val);
		drain();
		send_gap_pct = send_gap;
		take_gap_pct = take_gap;
		write_reg(CFG_MSS, mss_val);
		write_reg(CFG_INIT_WINDOW, win_val);
		write_reg(CFG_INIT_THRESHOLD, thr_val);
		write_reg(CFG_MAX_RETRIES, retry_val);
		end_writes();
		queue_traffic(185, era);
	endtask

	// Sender. An item handed over at this edge is predicted right here, and
	// the next one goes on the wire unless the sender chooses to idle.
	always @(posedge clk) begin : feed
		logic taken;
		taken = evt.valid && evt.ready;
		if (taken)
			due_results.insert(due_results.size(), reno_react(on_wire));
		if (!evt.valid || taken) begin
			if (arst_n && pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				on_wire = pending_events.pop_front();
				evt.valid <= 1'b1;
				evt.operation <= on_wire.operation;
				evt.ack_num <= on_wire.ack_num;
				evt.peer_window <= on_wire.peer_window;
				evt.seg_seq <= on_wire.seg_seq;
				evt.seg_len <= on_wire.seg_len;
				evt.retry_count <= on_wire.retry_count;
				evt.next_seq <= on_wire.next_seq;
				evt.data_end <= on_wire.data_end;
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	// Receiver. Every result must match the oldest prediction still waiting.
	always @(posedge clk) begin : observe
		win_res_t seen;
		win_res_t want;
		if (res.valid && res.ready) begin
			seen.cwnd = res.cwnd_out;
			seen.thresh = res.threshold_out;
			seen.ph = phase_t'(res.phase_out);
			seen.credit = res.send_credit;
			seen.rs = resend_t'(res.resend);
			seen.rseq = res.resend_seq;
			seen.rlen = res.resend_len;
			seen.rearm = res.rearm_count;
			seen.fatal = res.fatal;
			if (due_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: %s", show(seen));
			end else begin
				want = due_results.pop_front();
				if (seen !== want) begin
					faults++;
					if (faults <= 10) begin
						$display("mismatch, expected: %s", show(want));
						$display("          actual:   %s", show(seen));
					end
				end
			end
		end
		res.ready <= ($urandom_range(99) >= take_gap_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[reno_congestion_window_control_top] ERROR");
			$finish;
		end
	end

	initial begin
		// Everything the block sees is known from time zero on.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MSS;
		cfg_data = '0;
		evt.valid = 1'b0;
		evt.operation = OP_ACK;
		evt.ack_num = '0;
		evt.peer_window = '0;
		evt.seg_seq = '0;
		evt.seg_len = '0;
		evt.retry_count = '0;
		evt.next_seq = '0;
		evt.data_end = '0;
		res.ready = 1'b0;
		faults = 0;
		cycles = 0;
		send_gap_pct = 13;
		take_gap_pct = 64;

		// Connection state right after reset.
		snd_una = '0;
		dup_ack_seq = '0;
		dup_acks = '0;
		cwnd = WINDOW_RESET;
		ssthresh = THRESH_RESET;
		cc_phase = PH_SLOW;
		rwnd = '0;
		seg_size = MSS_RESET;
		retry_limit = RETRIES_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values. An ack equal to the reset base counts as a
		// repeat of the reset value of the recorded ack. Then a real ack, a
		// zero-length probe sitting at next_seq, and a timeout for a segment
		// that was acknowledged long ago.
		add_event(ack_evt(0, 16'hFFFF, 0, 32'hFFFF_FFFF));
		add_event(ack_evt(2048, 16'hFFFF, 1000, 32'hFFFF_FFFF));
		add_event(timer_evt(5000, 0, 0, 5000, 6000));
		add_event(timer_evt(0, 100, 0, 5000, 6000));
		drain();

		// Small threshold so slow start ends quickly, then a full fast
		// retransmit with data running out short of a whole segment, one more
		// repeat inside fast recovery, and the ack that leaves it while the
		// peer advertises a closed window.
		write_reg(CFG_MSS, 1000);
		write_reg(CFG_INIT_WINDOW, 2000);
		write_reg(CFG_INIT_THRESHOLD, 3000);
		write_reg(CFG_MAX_RETRIES, 15);
		end_writes();
		add_event(ack_evt(3000, 16'hFFFF, 3000, 32'hFFFF_FFFF));
		add_event(ack_evt(4000, 16'hFFFF, 4000, 32'hFFFF_FFFF));
		add_event(ack_evt(5000, 16'hFFFF, 5000, 32'hFFFF_FFFF));
		add_event(ack_evt(5000, 16'h8000, 5000, 32'hFFFF_FFFF));
		add_event(ack_evt(5000, 16'h4000, 5000, 32'hFFFF_FFFF));
		add_event(ack_evt(5000, 16'h2000, 5000, 32'hFFFF_FFFF));
		add_event(ack_evt(5000, 16'h1000, 5000, 5400));
		add_event(ack_evt(5000, 16'hFFFF, 5000, 32'hFFFF_FFFF));
		add_event(ack_evt(7000, 16'h0000, 7000, 9000));
		drain();

		// Loading the initial window while in avoidance leaves a zero window,
		// so the next growth divides by one. The largest segment size makes
		// that step huge. With no retries allowed a timeout with a nonzero retry count is fatal.
		write_reg(CFG_INIT_WINDOW, 0);
		write_reg(CFG_MSS, 16'hFFFF);
		write_reg(CFG_MAX_RETRIES, 0);
		end_writes();
		add_event(ack_evt(8000, 16'hFFFF, 8000, 32'hFFFF_FFFF));
		add_event(ack_evt(9000, 16'hFFFF, 9000, 32'hFFFF_FFFF));
		add_event(timer_evt(8500, 1000, 1, 9000, 9500));
		add_event(timer_evt(8500, 1000, 0, 9000, 9500));
		add_event(timer_evt(32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0));
		drain();

		// Large windows, smallest segment. A timeout at the top retry count
		// rearms without wrapping, and next_seq past the end of the data
		// leaves no credit.
		write_reg(CFG_MAX_RETRIES, 15);
		write_reg(CFG_MSS, 1);
		write_reg(CFG_INIT_WINDOW, 1048576);
		write_reg(CFG_INIT_THRESHOLD, 1048576);
		end_writes();
		add_event(timer_evt(9000, 16'hFFFF, 15, 9000, 9000));
		add_event(ack_evt(10000, 16'hFFFF, 20000, 15000));
		add_event(ack_evt(10000, 16'h0000, 0, 0));

		// Random eras. Each one starts after a full drain, which is also
		// where the sender sits still until the last result is back.
		run_era(2'd0, 13, 64, $urandom_range(500, 1500), $urandom_range(1000, 20000),
			$urandom_range(4000, 60000), $urandom_range(2, 8));
		run_era(2'd1, 64, 13, 16'hFFFF, 1048576, 1, 15);
		run_era(2'd2, 0, 0, $urandom_range(1, 65535), 1,
			$urandom_range(1, 1048576), $urandom_range(15));

		drain();
		repeat (50) @(posedge clk);
		if (faults == 0 && due_results.size() == 0)
			$display("[reno_congestion_window_control_top] OK");
		else
			$display("[reno_congestion_window_control_top] ERROR");
		$finish;
	end

endmodule
